[sv/hcr_pkg.sv]
`timescale 1ns / 1ps

package hcr_pkg;

  // Window geometry
  localparam int Window   = 5;
  localparam int Win      = Window | 1;
  localparam int Half     = Win / 2;
  localparam int WinSq    = Win * Win;
  localparam int Sigma    = 3;
  localparam int Sig      = (Sigma < 1) ? 1 : Sigma;
  localparam int MaxWidth = 1024;
  localparam int MaxRows  = 4096;
  localparam int MaxDist  = 2 * Half * Half;

  // Widths
  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxRows);
  localparam int SlotW  = $clog2(Win);
  localparam int IdxW   = $clog2(WinSq);
  localparam int AddrW  = SlotW + ColW;
  localparam int GradW  = 11;
  localparam int PixW   = 2 * GradW;
  localparam int WtW    = 17;
  localparam int AccW   = 46;
  localparam int SumW   = AccW - 16;
  localparam int RespW  = 45;
  localparam int CfgW   = 13;
  localparam int CfgIdxW = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegK      = 2'd2;

  typedef logic [WtW-1:0] weight_arr_t [WinSq];

  // Job handed to the tensor sequencer
  typedef struct packed {
    logic             start;
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  col;
  } hcr_job_t;

  // Shift-subtract long division, used only at elaboration
  function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem  = rem - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Normalized Gaussian weights, Q0.16, evaluated at elaboration
  function automatic weight_arr_t build_weights();
    weight_arr_t  res;
    logic [63:0]  m;
    logic [63:0]  term;
    logic [63:0]  den;
    logic signed [63:0] acc;
    logic [63:0]  r;
    logic [63:0]  pw [MaxDist+1];
    logic [63:0]  raw [WinSq];
    logic [63:0]  sum;
    int           d;
    m    = 64'(2 * Sig * Sig);
    term = 64'd1 << 32;
    acc  = $signed(term);
    for (int n = 1; n <= 24; n++) begin
      den  = m * 64'(n);
      term = div64(term, den);
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    r     = acc;
    pw[0] = 64'd1 << 32;
    for (int i = 1; i <= MaxDist; i++) begin
      pw[i] = (pw[i-1] * r + (64'd1 << 31)) >> 32;
    end
    sum = 64'd0;
    for (int a = 0; a < Win; a++) begin
      for (int b = 0; b < Win; b++) begin
        d = (a - Half) * (a - Half) + (b - Half) * (b - Half);
        raw[a*Win+b] = pw[d];
        sum = sum + pw[d];
      end
    end
    if (sum == 64'd0) sum = 64'd1;
    for (int i = 0; i < WinSq; i++) begin
      res[i] = WtW'(div64(raw[i] * 64'd65536 + sum / 2, sum));
    end
    return res;
  endfunction

  localparam weight_arr_t Weights = build_weights();

endpackage

[sv/harris_corner_response_top.sv]
`timescale 1ns / 1ps
// An interior pixel's result passes the tensor sequencer, the response pipeline and the output register.
// Throughput: border pixels go at one item per cycle while the block is idle; an interior pixel holds
// the input until its result enters the output register, as the single line-memory read port walks 25 window cells.
// Reset: counters, state and valid flags clear at once and configuration registers take their defaults;
// data registers and line memory are left as is and need no clearing pass.

module harris_corner_response_top import hcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // grad_x, grad_y
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [71:0]         m_axis_tdata,   // response, center_row, center_col
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StResp = 2'd2;
  localparam logic [1:0] StPush = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [10:0]      width_q;
  logic [12:0]      height_q;
  logic [CfgW-1:0]  k_q;
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [SlotW-1:0] slot_q;
  logic [RowW-1:0]  crow_q;
  logic [ColW-1:0]  ccol_q;
  logic             clast_q;
  logic             out_valid_q;
  logic [RespW-1:0] out_resp_q;
  logic [RowW-1:0]  out_row_q;
  logic [ColW-1:0]  out_col_q;
  logic             out_last_q;

  logic [11:0]      wc;
  logic [12:0]      hc;
  logic             accept, interior, last, wrap_col;
  logic [12:0]      r1;
  logic [SlotW-1:0] s1;
  logic [RowW-1:0]  r;
  logic [ColW-1:0]  c;
  logic [SlotW-1:0] s, s_next;
  logic [11:0]      cn;
  logic [12:0]      rn;
  logic             load_out;

  hcr_job_t               job;
  logic [AddrW-1:0]       rd_addr;
  logic [PixW-1:0]        rd_data;
  logic                   tens_done, resp_valid;
  logic signed [AccW-1:0] sxx, sxy, syy;
  logic signed [RespW-1:0] resp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
      k_q      <= 13'd3932;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i[10:0];
        RegHeight: height_q <= cfg_data_i;
        RegK:      k_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped frame size
  assign wc = (width_q > 11'(MaxWidth)) ? 12'(MaxWidth) :
              (width_q == '0) ? 12'd1 : {1'b0, width_q};
  assign hc = (height_q > 13'(MaxRows)) ? 13'(MaxRows) :
              (height_q == '0) ? 13'd1 : height_q;

  // Position of the incoming pixel
  always_comb begin
    wrap_col = ({2'b00, col_q} >= wc);
    c  = wrap_col ? '0 : col_q;
    r1 = wrap_col ? {1'b0, row_q} + 13'd1 : {1'b0, row_q};
    s1 = wrap_col ? ((slot_q == SlotW'(Win - 1)) ? '0 : slot_q + SlotW'(1)) : slot_q;
    if (r1 >= hc) begin
      r = '0;
      s = '0;
    end else begin
      r = r1[RowW-1:0];
      s = s1;
    end
    last     = ({1'b0, r} == hc - 13'd1) && ({2'b00, c} == wc - 12'd1);
    interior = (r >= RowW'(Win - 1)) && (c >= ColW'(Win - 1));
    cn       = {2'b00, c} + 12'd1;
    rn       = {1'b0, r} + 13'd1;
    s_next   = (s == SlotW'(Win - 1)) ? '0 : s + SlotW'(1);
  end

  // Raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (cn >= wc) begin
        col_q <= '0;
        if (rn >= hc) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= rn[RowW-1:0];
          slot_q <= s_next;
        end
      end else begin
        col_q  <= cn[ColW-1:0];
        row_q  <= r;
        slot_q <= s;
      end
    end
  end

  // Window job and center coordinates
  always_comb begin
    job.start = accept && interior;
    job.slot  = s_next;
    job.col   = c - ColW'(Win - 1);
  end

  always_ff @(posedge clk_i) begin
    if (job.start) begin
      crow_q  <= r - RowW'(Half);
      ccol_q  <= c - ColW'(Half);
      clast_q <= last;
    end
  end

  // Sequencer
  assign load_out = (state_q == StPush) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job.start) state_d = StRun;
      StRun:  if (tens_done) state_d = StResp;
      StResp: if (resp_valid) state_d = StPush;
      StPush: if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_resp_q <= resp;
      out_row_q  <= crow_q;
      out_col_q  <= ccol_q;
      out_last_q <= clast_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_col_q, out_row_q, out_resp_q};
  assign m_axis_tlast  = out_last_q;

  hcr_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i ({s, c}),
    .wdata_i (s_axis_tdata[PixW-1:0]),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  hcr_tensor u_tensor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (tens_done),
    .sxx_o     (sxx),
    .sxy_o     (sxy),
    .syy_o     (syy)
  );

  hcr_resp u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tens_done),
    .sxx_i   (sxx),
    .sxy_i   (sxy),
    .syy_i   (syy),
    .k_i     (k_q),
    .valid_o (resp_valid),
    .resp_o  (resp)
  );

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tens_done |-> state_q == StRun) else $error("window sums done outside run");
  a_resp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid |-> state_q == StResp) else $error("response outside wait");
  a_job_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.start |=> state_q == StRun) else $error("interior item did not start run");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q) else $error("result load lost");

endmodule

[sv/hcr_line_mem.sv]
`timescale 1ns / 1ps

module hcr_line_mem import hcr_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [PixW-1:0]  wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [PixW-1:0]  rdata_o
);

  // Row slot in the high bits, column in the low bits
  logic [PixW-1:0] mem [2**AddrW];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/hcr_tensor.sv]
`timescale 1ns / 1ps

module hcr_tensor import hcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hcr_job_t               job_i,
  output logic [AddrW-1:0]       rd_addr_o,
  input  logic [PixW-1:0]        rd_data_i,
  output logic                   done_o,
  output logic signed [AccW-1:0] sxx_o,
  output logic signed [AccW-1:0] sxy_o,
  output logic signed [AccW-1:0] syy_o
);

  logic             busy_q;
  logic [SlotW-1:0] a_q, b_q, slot_q;
  logic [ColW-1:0]  colb_q;
  logic [IdxW-1:0]  idx_q, idx1_q, idx2_q;
  logic             v1_q, v2_q, last1_q, last2_q, done_q;
  logic signed [2*GradW-1:0] pxx_q, pxy_q, pyy_q;
  logic signed [AccW-1:0]    axx_q, axy_q, ayy_q;
  logic             last_cell;
  logic signed [GradW-1:0]   gx, gy;
  logic signed [WtW:0]       wt;

  assign last_cell = (a_q == SlotW'(Win - 1)) && (b_q == SlotW'(Win - 1));
  assign rd_addr_o = {slot_q, colb_q + ColW'(b_q)};
  assign gx = $signed(rd_data_i[GradW-1:0]);
  assign gy = $signed(rd_data_i[PixW-1:GradW]);
  assign wt = $signed({1'b0, Weights[idx2_q]});

  // Address sequencer, one window cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v1_q    <= busy_q;
      last1_q <= busy_q && last_cell;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      done_q  <= v2_q && last2_q;
      if (job_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_cell) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.start) begin
      a_q    <= '0;
      b_q    <= '0;
      idx_q  <= '0;
      slot_q <= job_i.slot;
      colb_q <= job_i.col;
    end else if (busy_q) begin
      idx_q <= idx_q + IdxW'(1);
      if (b_q == SlotW'(Win - 1)) begin
        b_q    <= '0;
        a_q    <= a_q + SlotW'(1);
        slot_q <= (slot_q == SlotW'(Win - 1)) ? '0 : slot_q + SlotW'(1);
      end else begin
        b_q <= b_q + SlotW'(1);
      end
    end
    idx1_q <= idx_q;
    idx2_q <= idx1_q;
  end

  // Gradient products, then weighted accumulate
  always_ff @(posedge clk_i) begin
    pxx_q <= gx * gx;
    pxy_q <= gx * gy;
    pyy_q <= gy * gy;
    if (job_i.start) begin
      axx_q <= '0;
      axy_q <= '0;
      ayy_q <= '0;
    end else if (v2_q) begin
      axx_q <= axx_q + AccW'(wt * pxx_q);
      axy_q <= axy_q + AccW'(wt * pxy_q);
      ayy_q <= ayy_q + AccW'(wt * pyy_q);
    end
  end

  assign done_o = done_q;
  assign sxx_o  = axx_q;
  assign sxy_o  = axy_q;
  assign syy_o  = ayy_q;

endmodule

[sv/hcr_resp.sv]
`timescale 1ns / 1ps

module hcr_resp import hcr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [AccW-1:0]  sxx_i,
  input  logic signed [AccW-1:0]  sxy_i,
  input  logic signed [AccW-1:0]  syy_i,
  input  logic [CfgW-1:0]         k_i,
  output logic                    valid_o,
  output logic signed [RespW-1:0] resp_o
);

  localparam int ProdW = 2 * SumW;
  localparam int TrW   = SumW + 1;
  localparam int SqW   = 2 * TrW;
  localparam int LoW   = SqW / 2;
  localparam int HiW   = SqW - LoW;
  localparam int KlW   = CfgW + LoW;
  localparam int KhW   = CfgW + HiW;
  localparam int KtrW  = CfgW + SqW;
  localparam int DiffW = KtrW + 2;
  localparam logic signed [DiffW-1:0] RMax = DiffW'(64'sd17592186044415);
  localparam logic signed [DiffW-1:0] RMin = -DiffW'(64'sd17592186044416);

  // Truncate toward zero after dropping 16 fraction bits
  function automatic logic signed [SumW-1:0] trunc16(input logic signed [AccW-1:0] v);
    logic [AccW-1:0] mag;
    mag = v[AccW-1] ? AccW'(-v) : AccW'(v);
    return v[AccW-1] ? -$signed(SumW'(mag >> 16)) : $signed(SumW'(mag >> 16));
  endfunction

  logic [3:0] vld_q;
  logic signed [SumW-1:0]  sxx_q, sxy_q, syy_q;
  logic signed [TrW-1:0]   tr;
  logic signed [ProdW-1:0] pa_q, pb_q;
  logic [SqW-1:0]          trsq_q;
  logic signed [ProdW:0]   det_q;
  logic [KlW-1:0]          kl_q;
  logic [KhW-1:0]          kh_q;
  logic [KtrW-1:0]         ktr_full;
  logic signed [DiffW-1:0] diff;
  logic signed [RespW-1:0] resp_q;
  logic signed [SqW-1:0]   trsq_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign tr       = TrW'(sxx_q) + TrW'(syy_q);
  assign trsq_s   = tr * tr;
  assign ktr_full = (KtrW'(kh_q) << LoW) + KtrW'(kl_q);
  assign diff     = DiffW'(det_q) - $signed({2'b00, ktr_full >> 16});

  always_ff @(posedge clk_i) begin
    // Truncated tensor sums
    sxx_q <= trunc16(sxx_i);
    sxy_q <= trunc16(sxy_i);
    syy_q <= trunc16(syy_i);
    // Products and trace squared
    pa_q   <= sxx_q * syy_q;
    pb_q   <= sxy_q * sxy_q;
    trsq_q <= trsq_s;
    // Determinant and split k term
    det_q <= (ProdW+1)'(pa_q) - (ProdW+1)'(pb_q);
    kl_q  <= k_i * trsq_q[LoW-1:0];
    kh_q  <= k_i * trsq_q[SqW-1:LoW];
    // Saturate to the output range
    if (diff > RMax) resp_q <= RMax[RespW-1:0];
    else if (diff < RMin) resp_q <= RMin[RespW-1:0];
    else resp_q <= diff[RespW-1:0];
  end

  assign valid_o = vld_q[3];
  assign resp_o  = resp_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import hcr_pkg::*;

  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;  // unmapped index, must be ignored
  localparam int DrainCycles = 40;
  localparam longint CycleLimit = 3000000;
  localparam longint RespHi = 64'sd17592186044415;
  localparam longint RespLo = -64'sd17592186044416;

  typedef struct {
    logic [RespW-1:0] response;
    logic [11:0]      row;
    logic [9:0]       col;
    logic             last;
  } corner_t;

  // Predicts the corner response of each pixel and holds pending results
  class corner_board;
    shortint        gx_rows [Win][MaxWidth];
    shortint        gy_rows [Win][MaxWidth];
    longint         gauss [WinSq];
    int             width, height, k;
    int             row, col;
    corner_t        pending [$];

    function new();
      longint unsigned m, term, rate, sum;
      longint unsigned pw [MaxDist+1];
      longint          acc;
      int              d;
      foreach (gx_rows[i, j]) begin
        gx_rows[i][j] = 0;
        gy_rows[i][j] = 0;
      end
      // exp(-1/(2 sigma^2)) in Q32 by alternating series
      m    = 2 * Sig * Sig;
      term = 64'd1 << 32;
      acc  = term;
      for (int n = 1; n <= 24; n++) begin
        term = term / (m * n);
        if (n % 2 == 1) acc -= term;
        else acc += term;
      end
      rate  = acc;
      pw[0] = 64'd1 << 32;
      for (int i = 1; i <= MaxDist; i++) pw[i] = (pw[i-1] * rate + (64'd1 << 31)) >> 32;
      sum = 0;
      for (int a = 0; a < Win; a++) begin
        for (int b = 0; b < Win; b++) begin
          d = (a - Half) * (a - Half) + (b - Half) * (b - Half);
          sum += pw[d];
        end
      end
      if (sum == 0) sum = 1;
      for (int a = 0; a < Win; a++) begin
        for (int b = 0; b < Win; b++) begin
          d = (a - Half) * (a - Half) + (b - Half) * (b - Half);
          gauss[a*Win+b] = (pw[d] * 65536 + sum / 2) / sum;
        end
      end
      width  = 640;
      height = 480;
      k      = 3932;
      row    = 0;
      col    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegWidth:  width  = data[10:0];
        RegHeight: height = data;
        RegK:      k      = data;
        default: ;
      endcase
    endfunction

    static function longint drop16(longint v);
      if (v < 0) return -((-v) >>> 16);
      return v >>> 16;
    endfunction

    // Accepted pixel: store it and queue a result for interior pixels
    function void take_pixel(logic signed [GradW-1:0] gx, logic signed [GradW-1:0] gy);
      int w, h, r, c, rs, cc;
      longint axx, axy, ayy, sxx, sxy, syy, tr, resp, px, py;
      longint unsigned ktr;
      corner_t res;
      w = (width > MaxWidth) ? MaxWidth : ((width < 1) ? 1 : width);
      h = (height > MaxRows) ? MaxRows : ((height < 1) ? 1 : height);
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      r = row;
      c = col;
      gx_rows[r % Win][c] = gx;
      gy_rows[r % Win][c] = gy;
      if (r >= Win - 1 && c >= Win - 1) begin
        axx = 0;
        axy = 0;
        ayy = 0;
        for (int a = 0; a < Win; a++) begin
          rs = (r + 1 + a) % Win;
          for (int b = 0; b < Win; b++) begin
            cc = c - (Win - 1) + b;
            px = gx_rows[rs][cc];
            py = gy_rows[rs][cc];
            axx += gauss[a*Win+b] * px * px;
            axy += gauss[a*Win+b] * px * py;
            ayy += gauss[a*Win+b] * py * py;
          end
        end
        sxx  = drop16(axx);
        sxy  = drop16(axy);
        syy  = drop16(ayy);
        tr   = sxx + syy;
        ktr  = (longint'(k) * (tr * tr)) >> 16;
        resp = sxx * syy - sxy * sxy - longint'(ktr);
        if (resp > RespHi) resp = RespHi;
        if (resp < RespLo) resp = RespLo;
        res.response = resp[RespW-1:0];
        res.row      = 12'(r - Half);
        res.col      = 10'(c - Half);
        res.last     = (r == h - 1) && (c == w - 1);
        pending.push_back(res);
      end
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row = r + 1;
        if (row >= h) row = 0;
      end
    endfunction

    // Empty string when the result matches the oldest pending one
    function string check_result(corner_t got);
      corner_t want;
      string   msg;
      if (pending.size() == 0) return $sformatf("unexpected result row %0d col %0d",
                                                got.row, got.col);
      want = pending.pop_front();
      msg  = "";
      if (got.response !== want.response)
        msg = {msg, $sformatf(" response %0d/%0d", $signed(got.response),
                              $signed(want.response))};
      if (got.row !== want.row) msg = {msg, $sformatf(" row %0d/%0d", got.row, want.row)};
      if (got.col !== want.col) msg = {msg, $sformatf(" col %0d/%0d", got.col, want.col)};
      if (got.last !== want.last) msg = {msg, $sformatf(" last %0b/%0b", got.last, want.last)};
      if (msg != "") msg = $sformatf("mismatch at row %0d col %0d (got/exp):%s",
                                     want.row, want.col, msg);
      return msg;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [71:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  corner_board board;
  int          errors;
  bit          quiet;      // no idling on either side
  int          pixels_sent;
  longint      cycles;
  int          out_stall;

  harris_corner_response_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // Runaway guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each accepted item, stall in random bursts
  always @(posedge clk_i) begin
    corner_t got;
    string   msg;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.response = m_axis_tdata[RespW-1:0];
        got.row      = m_axis_tdata[RespW+11:RespW];
        got.col      = m_axis_tdata[RespW+21:RespW+12];
        got.last     = m_axis_tlast;
        msg = board.check_result(got);
        if (msg != "") report(msg);
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(int gx, int gy);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, 11'(gy), 11'(gx)};
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_pixel(11'(gx), 11'(gy));
    pixels_sent++;
  endtask

  // Let the block drain before touching its registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.write_reg(idx, CfgW'(data));
    @(posedge clk_i);
  endtask

  task automatic set_frame(int w, int h, int kq);
    settle();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegK, kq);
  endtask

  function automatic int rand_grad();
    case ($urandom_range(0, 5))
      0: return 1020;
      1: return -1020;
      2: return $urandom_range(0, 40) - 20;
      default: return $urandom_range(0, 2040) - 1020;
    endcase
  endfunction

  task automatic send_random_frame(int w, int h);
    for (int i = 0; i < w * h; i++) send_pixel(rand_grad(), rand_grad());
  endtask

  initial begin
    int gx, gy;
    board         = new();
    errors        = 0;
    quiet         = 1'b0;
    pixels_sent   = 0;
    cycles        = 0;
    out_stall     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegWidth;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame with one interior pixel, field extremes, k at zero
    set_frame(5, 5, 0);
    for (int i = 0; i < 25; i++) begin
      gx = (i % 3 == 0) ? 1020 : ((i % 3 == 1) ? -1020 : 0);
      gy = (i % 2 == 0) ? -1020 : 1020;
      send_pixel(gx, gy);
    end
    // k at 6554, frame smaller than the window, unmapped register write
    set_frame(3, 3, 6554);
    write_reg(RegNone, 1234);
    send_random_frame(3, 3);
    set_frame(4, 6, 6554);
    send_random_frame(4, 6);

    // Random frames of small size
    while (pixels_sent < 350) begin
      set_frame($urandom_range(5, 24), $urandom_range(3, 12), $urandom_range(0, 6554));
      send_random_frame(board.width, board.height);
    end

    // Last part runs without idling
    settle();
    quiet = 1'b1;
    set_frame($urandom_range(6, 16), $urandom_range(5, 9), $urandom_range(0, 6554));
    send_random_frame(board.width, board.height);
    send_random_frame(board.width, board.height);

    settle();
    if (board.pending.size() != 0) report("results still pending at end");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
